/* rtl/ogi_pkg.sv */
package ogi_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MAX_RADIUS = 15;

  localparam int unsigned CoordW  = $clog2(MAX_WIDTH);
  localparam int unsigned RowW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SizeW   = 9;
  localparam int unsigned RadW    = 4;
  localparam int unsigned DeltaW  = RadW + 1;
  localparam int unsigned CellW   = 8;
  localparam int unsigned AddrW   = CoordW + RowW;
  localparam int unsigned GridDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [CellW-1:0] CELL_OCCUPIED = 8'sd100;
  localparam logic signed [CellW-1:0] CELL_UNKNOWN  = -8'sd1;
  localparam logic signed [CellW-1:0] CELL_FREE     = 8'sd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_WIDTH      = 3'd0,
    REG_MAP_HEIGHT     = 3'd1,
    REG_RADIUS_CELLS   = 3'd2,
    REG_OCCUPIED_LEVEL = 3'd3,
    REG_KEEP_UNKNOWN   = 3'd4,
    REG_ROUND_WINDOW   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_CENTER,
    SC_SCAN,
    SC_DRAIN,
    SC_FINISH
  } scan_state_e;

  typedef struct packed {
    logic [SizeW-1:0]        width;
    logic [SizeW-1:0]        height;
    logic [RadW-1:0]         radius;
    logic signed [CellW-1:0] level;
    logic                    keep;
    logic                    round;
  } ogi_cfg_t;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] x;
    logic [RowW-1:0]   y;
  } ogi_req_t;

  typedef struct packed {
    logic                    valid;
    logic signed [CellW-1:0] value;
  } ogi_res_t;

endpackage

/* rtl/occupancy_grid_inflation.sv */
// channel | direction | handshake                  | payload
// in      | request   | in_valid_i / in_stall_o    | mode, cell_x, cell_y, cell_value
// out     | result    | out_valid_o / out_stall_i  | inflated_value, outside_map
// cfg     | write     | cfg_we_i, cfg_idx_i        | cfg_wdata_i
// A write request and a query outside the map are taken without a scan.
// A query inside the map reads the center cell, then scans the window (ending early on an obstacle
// hit, skipped when the center cell is kept unknown): one grid read per window cell in the map,
// all through the single read port of the grid memory, checked by one shared compare.
// Reset clears control and loads default configuration; the grid is not cleared and holds
// garbage until written. A request is held off while a stalled result waits in the output
// register; a query that finishes while that register is still stalled holds until it is taken.
module occupancy_grid_inflation
  import ogi_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic [CoordW-1:0]       cell_x_i,
  input  logic [RowW-1:0]         cell_y_i,
  input  logic signed [CellW-1:0] cell_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [CellW-1:0] inflated_value_o,
  output logic                    outside_map_o
);

  logic [SizeW-1:0]        map_width_q, map_height_q;
  logic [RadW-1:0]         radius_q;
  logic signed [CellW-1:0] level_q;
  logic                    keep_q, round_q;

  logic                    out_valid_q;
  logic signed [CellW-1:0] out_value_q;
  logic                    out_outside_q;

  ogi_cfg_t   cfg;
  ogi_req_t   req;
  ogi_res_t   res;
  logic       busy, out_free, in_acc, in_map, is_query;
  logic       rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [CellW-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= SizeW'(256);
      map_height_q <= SizeW'(256);
      radius_q     <= RadW'(2);
      level_q      <= 8'sd50;
      keep_q       <= 1'b1;
      round_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAP_WIDTH:      map_width_q  <= cfg_wdata_i[SizeW-1:0];
        REG_MAP_HEIGHT:     map_height_q <= cfg_wdata_i[SizeW-1:0];
        REG_RADIUS_CELLS:   radius_q     <= cfg_wdata_i[RadW-1:0];
        REG_OCCUPIED_LEVEL: level_q      <= signed'(cfg_wdata_i[CellW-1:0]);
        REG_KEEP_UNKNOWN:   keep_q       <= cfg_wdata_i[0];
        REG_ROUND_WINDOW:   round_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.width  = (32'(map_width_q) > MAX_WIDTH) ? SizeW'(MAX_WIDTH) : map_width_q;
  assign cfg.height = (32'(map_height_q) > MAX_HEIGHT) ? SizeW'(MAX_HEIGHT) : map_height_q;
  assign cfg.radius = radius_q;
  assign cfg.level  = level_q;
  assign cfg.keep   = keep_q;
  assign cfg.round  = round_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_query   = (mode_i == MODE_QUERY);
  assign in_map     = ({1'b0, cell_x_i} < cfg.width) && ({1'b0, cell_y_i} < cfg.height);

  assign req.start = in_acc && is_query && in_map;
  assign req.x     = cell_x_i;
  assign req.y     = cell_y_i;

  ogi_grid_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && !is_query && in_map),
    .wr_addr_i ({cell_y_i, cell_x_i}),
    .wr_data_i (cell_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ogi_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (req),
    .out_free_i (out_free),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid || (in_acc && is_query && !in_map);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (res.valid) begin
        out_value_q   <= res.value;
        out_outside_q <= 1'b0;
      end else begin
        out_value_q   <= CELL_FREE;
        out_outside_q <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign inflated_value_o = out_value_q;
  assign outside_map_o    = out_outside_q;

endmodule

/* rtl/ogi_grid_mem.sv */
module ogi_grid_mem
  import ogi_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [CellW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [CellW-1:0] rd_data_o
);

  logic [CellW-1:0] mem_q [GridDepth];
  logic [CellW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/ogi_scan.sv */
module ogi_scan
  import ogi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ogi_cfg_t         cfg_i,
  input  ogi_req_t         req_i,
  input  logic             out_free_i,
  output logic             busy_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [CellW-1:0] rd_data_i,
  output ogi_res_t         res_o
);

  scan_state_e              state_q, state_d;
  logic [CoordW-1:0]        x_q, x_d;
  logic [RowW-1:0]          y_q, y_d;
  logic signed [DeltaW-1:0] dx_q, dx_d;
  logic signed [DeltaW-1:0] dy_q, dy_d;
  logic                     pend_q, pend_d;
  logic                     hit_q, hit_d;
  logic                     unk_q, unk_d;

  logic signed [DeltaW-1:0] r_s;
  logic signed [CoordW+1:0] nx;
  logic signed [RowW+1:0]   ny;
  logic [RadW-1:0]          adx, ady;
  logic [2*RadW-1:0]        sqx, sqy, rr;
  logic [2*RadW:0]          win_sq;
  logic                     in_win, in_map, hit_now, last;
  logic [RadW-1:0]          r_eff;

  assign r_eff = (32'(cfg_i.radius) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : cfg_i.radius;
  assign r_s   = signed'({1'b0, r_eff});

  assign nx  = signed'({2'b00, x_q}) + (CoordW+2)'(dx_q);
  assign ny  = signed'({2'b00, y_q}) + (RowW+2)'(dy_q);
  assign adx = dx_q[DeltaW-1] ? RadW'(-dx_q) : dx_q[RadW-1:0];
  assign ady = dy_q[DeltaW-1] ? RadW'(-dy_q) : dy_q[RadW-1:0];
  assign sqx = (2*RadW)'(adx) * (2*RadW)'(adx);
  assign sqy = (2*RadW)'(ady) * (2*RadW)'(ady);
  assign rr  = (2*RadW)'(r_eff) * (2*RadW)'(r_eff);
  assign win_sq = {1'b0, sqx} + {1'b0, sqy};

  assign in_win = !cfg_i.round || (win_sq <= {1'b0, rr});
  assign in_map = !nx[CoordW+1] && ({1'b0, nx[CoordW:0]} < (CoordW+2)'(cfg_i.width))
               && !ny[RowW+1] && ({1'b0, ny[RowW:0]} < (RowW+2)'(cfg_i.height));

  // shared compare: the one cell that came back from memory against the threshold
  assign hit_now = pend_q && (signed'(rd_data_i) >= cfg_i.level);
  assign last    = (dx_q == r_s) && (dy_q == r_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      unk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      unk_q   <= unk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    pend_d    = 1'b0;
    hit_d     = hit_q;
    unk_d     = unk_q;
    rd_en_o   = 1'b0;
    rd_addr_o = {ny[RowW-1:0], nx[CoordW-1:0]};
    res_o.valid = 1'b0;
    res_o.value = unk_q ? CELL_UNKNOWN : (hit_q ? CELL_OCCUPIED : CELL_FREE);
    case (state_q)
      SC_IDLE: begin
        rd_addr_o = {req_i.y, req_i.x};
        if (req_i.start) begin
          rd_en_o = 1'b1;
          x_d     = req_i.x;
          y_d     = req_i.y;
          hit_d   = 1'b0;
          unk_d   = 1'b0;
          state_d = SC_CENTER;
        end
      end
      SC_CENTER: begin
        dx_d = -r_s;
        dy_d = -r_s;
        if (cfg_i.keep && (signed'(rd_data_i) == CELL_UNKNOWN)) begin
          unk_d   = 1'b1;
          state_d = SC_FINISH;
        end else begin
          state_d = SC_SCAN;
        end
      end
      SC_SCAN: begin
        if (hit_now) begin
          hit_d   = 1'b1;
          state_d = SC_FINISH;
        end else begin
          if (in_win && in_map) begin
            rd_en_o = 1'b1;
            pend_d  = 1'b1;
          end
          if (dx_q == r_s) begin
            dx_d = -r_s;
            dy_d = dy_q + DeltaW'(1);
          end else begin
            dx_d = dx_q + DeltaW'(1);
          end
          if (last) begin
            state_d = SC_DRAIN;
          end
        end
      end
      SC_DRAIN: begin
        hit_d   = hit_now;
        state_d = SC_FINISH;
      end
      SC_FINISH: begin
        res_o.valid = 1'b1;
        if (out_free_i) begin
          state_d = SC_IDLE;
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != SC_IDLE);

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SC_IDLE && !req_i.start) |-> !rd_en_o)
    else $error("memory read without a request");

  a_finish_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(unk_q && hit_q) && !rd_en_o)
    else $error("result both unknown and occupied");

  a_center_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SC_IDLE && req_i.start) |=> (state_q == SC_CENTER))
    else $error("query did not start with the center read");

  a_scan_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_o && state_q == SC_SCAN) |->
      ({1'b0, rd_addr_o[CoordW-1:0]} < cfg_i.width))
    else $error("window read outside the map");

endmodule
